// ----- hw/rtl/rrs_pkg.sv -----
package rrs_pkg;

  // Fixed field widths of the request and the response.
  localparam int unsigned TID_W   = 32;
  localparam int unsigned SLICE_W = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned TOTAL_W = 32;

  // The slot index field is four bits wide, so only the first sixteen slots can
  // ever be queued and read back.
  localparam int unsigned SLOT_LIMIT = 16;

  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_ENQUEUE = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_BAD_ENQ = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TID_W-1:0]   thread_id;
    logic [SLICE_W-1:0] slice_length;
    logic [SLOT_W-1:0]  slot_index;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot_out;
    logic [TID_W-1:0]   running_tid;
    logic               running_valid;
    logic [TOTAL_W-1:0] ready_total;
  } out_rsp_t;

  // What the thread table holds for one slot.
  typedef struct packed {
    logic [TID_W-1:0]   tid;
    logic [SLICE_W-1:0] slice;
  } thread_rec_t;

  // One place in the ready ring: the slot with a copy of its table record.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    thread_rec_t       rec;
  } ring_entry_t;

  typedef struct packed {
    logic wr_en;
    logic mark_en;
  } slot_ctl_t;

  typedef struct packed {
    logic push;
    logic rotate;
  } ring_op_t;

endpackage

// ----- hw/rtl/rrs_slots.sv -----
module rrs_slots #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rrs_pkg::slot_ctl_t       ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rrs_pkg::thread_rec_t     wr_rec,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output rrs_pkg::thread_rec_t     rd_rec,
  output logic                     rd_queued
);
  import rrs_pkg::*;

  thread_rec_t      table_r [DEPTH];
  logic [DEPTH-1:0] queued_r;
  logic [DEPTH-1:0] queued_nxt;

  // Thread records are written once, when the slot is created.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      table_r[wr_addr] <= wr_rec;
    end
  end

  // Queued flags are set by a successful enqueue and cleared only by reset.
  always_comb begin
    queued_nxt = queued_r;
    if (ctl.mark_en) begin
      queued_nxt[rd_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r <= '0;
    end else begin
      queued_r <= queued_nxt;
    end
  end

  assign rd_rec    = table_r[rd_addr];
  assign rd_queued = queued_r[rd_addr];

endmodule

// ----- hw/rtl/rrs_ring.sv -----
module rrs_ring #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rrs_pkg::ring_op_t          op,
  input  rrs_pkg::ring_entry_t       push_entry,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output rrs_pkg::ring_entry_t       head,
  output rrs_pkg::ring_entry_t       second
);
  import rrs_pkg::*;

  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  // The ring is kept as a row of cells with the running thread always in
  // cell 0. A rotation shifts every cell down by one and drops the old head
  // into the last occupied cell; a push writes the first free cell.
  ring_entry_t        ring_r [DEPTH];
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ring_entry_t cell_nxt;

    if (i < DEPTH - 1) begin : g_mid
      always_comb begin
        cell_nxt = ring_r[i];
        if (op.rotate) begin
          cell_nxt = (count_r == COUNT_W'(i + 1)) ? ring_r[0] : ring_r[i + 1];
        end else if (op.push && (count_r == COUNT_W'(i))) begin
          cell_nxt = push_entry;
        end
      end
    end else begin : g_last
      always_comb begin
        cell_nxt = ring_r[i];
        if (op.rotate) begin
          if (count_r == COUNT_W'(i + 1)) begin
            cell_nxt = ring_r[0];
          end
        end else if (op.push && (count_r == COUNT_W'(i))) begin
          cell_nxt = push_entry;
        end
      end
    end

    always_ff @(posedge clk) begin
      ring_r[i] <= cell_nxt;
    end
  end

  // Slots never leave the ring, so the fill count only grows.
  always_comb begin
    count_nxt = count_r;
    if (op.push) begin
      count_nxt = count_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count  = count_r;
  assign head   = ring_r[0];
  assign second = ring_r[1];

endmodule

// ----- hw/rtl/round_robin_slice_scheduler.sv -----
// Channel | Ports                          | Moves
// --------+--------------------------------+-----------------------------------
// request | in_valid, in_ready, in_req     | create, enqueue, tick or nop request
// result  | out_valid, out_ready, out_rsp  | status, slot and running thread
//
// One request is taken every cycle while results are taken; each is accepted
// into the request register and its result moves to the result register.
// The whole request is handled in the one stage between the request register
// and the result register, and all state moves there.
// Reset (rst_n low at a clock edge) empties the ring, clears the queued flags,
// the slot and enqueue counters and the running flag; thread records are
// written by create only. A stalled result holds the stage, and the request
// register then holds one waiting request.
module round_robin_slice_scheduler #(
  parameter int unsigned MAX_THREADS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrs_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output rrs_pkg::out_rsp_t out_rsp
);
  import rrs_pkg::*;

  localparam int unsigned TABLE_DEPTH = (MAX_THREADS < SLOT_LIMIT) ? MAX_THREADS : SLOT_LIMIT;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned USED_W      = $clog2(MAX_THREADS + 1);
  localparam int unsigned CMP_W       = (USED_W > SLOT_W) ? USED_W : SLOT_W;

  in_req_t             req_r;
  logic                req_valid_r;
  logic                req_valid_nxt;
  out_rsp_t            rsp_r;
  out_rsp_t            rsp_nxt;
  logic                rsp_valid_r;
  logic                rsp_valid_nxt;
  logic [USED_W-1:0]   used_r;
  logic [USED_W-1:0]   used_nxt;
  logic [SLICE_W-1:0]  head_rem_r;
  logic [SLICE_W-1:0]  head_rem_nxt;
  logic                running_r;
  logic                running_nxt;
  logic [TOTAL_W-1:0]  total_r;
  logic [TOTAL_W-1:0]  total_nxt;

  logic                advance;
  logic                in_take;
  logic [CMP_W-1:0]    used_ext;
  logic [CMP_W-1:0]    slot_ext;
  logic                table_full;
  logic                create_ok;
  logic                enq_ok;
  logic                tick_ok;
  logic                rotate;
  logic [SLICE_W-1:0]  rem_dec;
  slot_ctl_t           slot_ctl;
  thread_rec_t         wr_rec;
  thread_rec_t         rd_rec;
  logic                rd_queued;
  ring_op_t            ring_op;
  ring_entry_t         push_entry;
  ring_entry_t         ring_head;
  ring_entry_t         ring_second;
  ring_entry_t         new_head;
  logic [COUNT_W-1:0]  ring_count;

  // Request register and result register handshake.
  assign advance  = req_valid_r && (!rsp_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_take) begin
      req_valid_nxt = 1'b1;
    end else if (advance) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    rsp_valid_nxt = rsp_valid_r;
    if (advance) begin
      rsp_valid_nxt = 1'b1;
    end else if (out_ready) begin
      rsp_valid_nxt = 1'b0;
    end
  end

  // Decode of the request held in the request register.
  assign used_ext   = CMP_W'(used_r);
  assign slot_ext   = CMP_W'(req_r.slot_index);
  assign table_full = (used_r >= USED_W'(MAX_THREADS));

  assign create_ok = advance && (kind_t'(req_r.kind) == KIND_CREATE) && !table_full;
  assign enq_ok    = advance && (kind_t'(req_r.kind) == KIND_ENQUEUE)
                     && (slot_ext < used_ext) && !rd_queued
                     && (ring_count < COUNT_W'(TABLE_DEPTH));
  assign tick_ok   = advance && (kind_t'(req_r.kind) == KIND_TICK)
                     && (ring_count != '0);

  // Charge one tick to the head; rotate once it is spent and another waits.
  assign rem_dec = (head_rem_r == '0) ? '0 : head_rem_r - SLICE_W'(1);
  assign rotate  = tick_ok && (rem_dec == '0) && (ring_count >= COUNT_W'(2));

  // Thread table and queued flags.
  assign slot_ctl.wr_en   = create_ok && (used_r < USED_W'(TABLE_DEPTH));
  assign slot_ctl.mark_en = enq_ok;
  assign wr_rec.tid       = req_r.thread_id;
  assign wr_rec.slice     = req_r.slice_length;

  rrs_slots #(
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (slot_ctl),
    .wr_addr   (used_r[ADDR_W-1:0]),
    .wr_rec    (wr_rec),
    .rd_addr   (req_r.slot_index[ADDR_W-1:0]),
    .rd_rec    (rd_rec),
    .rd_queued (rd_queued)
  );

  // Ready ring.
  assign ring_op.push    = enq_ok;
  assign ring_op.rotate  = rotate;
  assign push_entry.slot = req_r.slot_index;
  assign push_entry.rec  = rd_rec;

  rrs_ring #(
    .DEPTH (TABLE_DEPTH)
  ) u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (ring_op),
    .push_entry (push_entry),
    .count      (ring_count),
    .head       (ring_head),
    .second     (ring_second)
  );

  // Only the head's remaining ticks ever differ from its slice, so one
  // register stands for the whole remaining-ticks table.
  always_comb begin
    head_rem_nxt = head_rem_r;
    if (enq_ok && (ring_count == '0)) begin
      head_rem_nxt = rd_rec.slice;
    end else if (tick_ok) begin
      head_rem_nxt = rotate ? ring_second.rec.slice : rem_dec;
    end
  end

  // Slot, running and enqueue counters.
  always_comb begin
    used_nxt    = create_ok ? used_r + USED_W'(1) : used_r;
    running_nxt = running_r || tick_ok;
    total_nxt   = total_r;
    if (enq_ok && (total_r != '1)) begin
      total_nxt = total_r + TOTAL_W'(1);
    end
  end

  // Result of the request as seen after its state change.
  assign new_head = rotate ? ring_second : ring_head;

  always_comb begin
    rsp_nxt               = '0;
    rsp_nxt.running_valid = running_nxt;
    rsp_nxt.running_tid   = running_nxt ? new_head.rec.tid : '0;
    rsp_nxt.ready_total   = total_nxt;
    case (kind_t'(req_r.kind))
      KIND_CREATE: begin
        if (table_full) begin
          rsp_nxt.status = STAT_FULL;
        end else begin
          rsp_nxt.status   = STAT_OK;
          rsp_nxt.slot_out = used_ext[SLOT_W-1:0];
        end
      end
      KIND_ENQUEUE: begin
        rsp_nxt.status   = enq_ok ? STAT_OK : STAT_BAD_ENQ;
        rsp_nxt.slot_out = req_r.slot_index;
      end
      KIND_TICK: begin
        if (tick_ok) begin
          rsp_nxt.status   = STAT_OK;
          rsp_nxt.slot_out = new_head.slot;
        end else begin
          rsp_nxt.status = STAT_EMPTY;
        end
      end
      KIND_NOP: begin
        rsp_nxt.status = STAT_OK;
      end
      default: begin
        rsp_nxt.status = STAT_OK;
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_req;
    end
    if (advance) begin
      rsp_r      <= rsp_nxt;
      head_rem_r <= head_rem_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
      used_r      <= '0;
      running_r   <= 1'b0;
      total_r     <= '0;
    end else begin
      req_valid_r <= req_valid_nxt;
      rsp_valid_r <= rsp_valid_nxt;
      used_r      <= used_nxt;
      running_r   <= running_nxt;
      total_r     <= total_nxt;
    end
  end

  assign out_valid = rsp_valid_r;
  assign out_rsp   = rsp_r;

  // The slot counter never passes the number of slots.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(MAX_THREADS))
    else $error("slot counter beyond table size");

  // The ring never holds more slots than have been created.
  a_ring_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    USED_W'(ring_count) <= used_r)
    else $error("ring holds more slots than created");

  // A running thread implies a non-empty ring.
  a_running_ring: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (ring_count != '0))
    else $error("running flag set with empty ring");

  // A waiting request is not lost while the result side stalls.
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && !advance) |=> (req_valid_r && $stable(req_r)))
    else $error("request register changed while stalled");

endmodule
